/* rtl/load_cell_adc_serial_reader_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the load cell reader.
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef LOAD_CELL_ADC_SERIAL_READER_ASSERT_SVH
`define LOAD_CELL_ADC_SERIAL_READER_ASSERT_SVH

// same-cycle implication
`define LCSR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LCSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lcsr_pkg.sv */
// ----------------------------------------------------------------------------
// lcsr_pkg
// Types and constants shared by the load cell reader modules.
// ----------------------------------------------------------------------------
package lcsr_pkg;

	localparam int DEF_SAMPLE_BITS = 24;
	localparam int DEF_QUEUE_DEPTH = 4;
	localparam int VALUE_W         = 24;

	// operation codes on the input field
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_PDOWN = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_GAIN  = 2'd0;
	localparam logic [1:0] CFG_HALF  = 2'd1;
	localparam logic [1:0] CFG_AVG   = 2'd2;
	localparam logic [1:0] CFG_TARE  = 2'd3;

	localparam logic [1:0]  RST_GAIN = 2'd1;
	localparam logic [15:0] RST_HALF = 16'd20;
	localparam logic [7:0]  RST_AVG  = 8'd1;

	// classified operation handed from front to back
	typedef enum logic [1:0] {
		OPC_TICK  = 2'd0,
		OPC_START = 2'd1,
		OPC_PDOWN = 2'd2
	} opc_t;

	typedef struct packed {
		opc_t opc;
		logic data_level;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         gain_pulses;
		logic [15:0]        half_period_ticks;
		logic [7:0]         average_count;
		logic [VALUE_W-1:0] tare_offset;
	} cfg_t;

	typedef struct packed {
		logic               serial_clock;
		logic               busy_res;
		logic               done_res;
		logic [VALUE_W-1:0] average_value;
		logic [VALUE_W-1:0] net_value;
	} out_item_t;

endpackage

/* rtl/load_cell_adc_serial_reader.sv */
// ----------------------------------------------------------------------------
// load_cell_adc_serial_reader
// Two-wire serial reader for a 24-bit load cell converter with averaging.
// ----------------------------------------------------------------------------
// Each input transfer is one time tick: an operation (tick, start, power
// down) and the level of the converter's data pin. Each tick yields exactly
// one result transfer: the clock pin level, busy, done, and the last average
// and tare-corrected net value. The front end classifies operations into a
// short input queue; the back end runs the clock sequencer. The tick that
// completes a measurement also runs the bit-serial divider that forms the
// average: the accepting cycle launches it, it forms SAMPLE_BITS + 8 quotient
// bits, then the quotient is captured, then the tare subtract and the result
// push follow. A full result queue stretches any tick.
// Input and result queues of QUEUE_DEPTH entries let either side stall
// without holding up the other. Configuration writes are always ready and
// take effect on the next tick; write them only while the block is idle.
// ----------------------------------------------------------------------------
module load_cell_adc_serial_reader #(
	parameter int SAMPLE_BITS = lcsr_pkg::DEF_SAMPLE_BITS,
	parameter int QUEUE_DEPTH = lcsr_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// tick input queue
	input  logic                         push,
	output logic                         full,
	input  logic [1:0]                   operation,
	input  logic                         data_level,
	// result queue
	output logic                         empty,
	input  logic                         pop,
	output logic                         serial_clock,
	output logic                         busy_res,
	output logic                         done_res,
	output logic [lcsr_pkg::VALUE_W-1:0] average_value,
	output logic [lcsr_pkg::VALUE_W-1:0] net_value,
	// configuration writes
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [lcsr_pkg::VALUE_W-1:0] cfg_data
);
	import lcsr_pkg::*;

	cfg_t      cfg_q;
	in_item_t  in_wr, in_head;
	out_item_t out_wr, out_head;
	logic      in_empty, in_pop, out_full, out_push;

	// Configuration registers; every index of the port maps to a register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_pulses       <= RST_GAIN;
			cfg_q.half_period_ticks <= RST_HALF;
			cfg_q.average_count     <= RST_AVG;
			cfg_q.tare_offset       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GAIN: cfg_q.gain_pulses       <= cfg_data[1:0];
				CFG_HALF: cfg_q.half_period_ticks <= cfg_data[15:0];
				CFG_AVG:  cfg_q.average_count     <= cfg_data[7:0];
				CFG_TARE: cfg_q.tare_offset       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front end: classify the operation. The unused code acts as a plain tick.
	always_comb begin
		in_wr.data_level = data_level;
		unique case (operation)
			OP_START: in_wr.opc = OPC_START;
			OP_PDOWN: in_wr.opc = OPC_PDOWN;
			OP_TICK:  in_wr.opc = OPC_TICK;
			default:  in_wr.opc = OPC_TICK;
		endcase
	end

	lcsr_fifo #(
		.WIDTH($bits(in_item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_in_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (in_wr),
		.full    (full),
		.rd_en   (in_pop),
		.rd_data (in_head),
		.empty   (in_empty)
	);

	// Back end: sequencer, accumulator and divider.
	lcsr_core #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (!in_empty),
		.in_item  (in_head),
		.in_pop   (in_pop),
		.out_full (out_full),
		.out_push (out_push),
		.out_item (out_wr)
	);

	// Results wait here until the consumer takes them.
	lcsr_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_wr),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (out_head),
		.empty   (empty)
	);

	assign serial_clock  = out_head.serial_clock;
	assign busy_res      = out_head.busy_res;
	assign done_res      = out_head.done_res;
	assign average_value = out_head.average_value;
	assign net_value     = out_head.net_value;

endmodule

/* rtl/lcsr_fifo.sv */
// ----------------------------------------------------------------------------
// lcsr_fifo
// Small register queue, head shown combinationally.
// ----------------------------------------------------------------------------
module lcsr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

/* rtl/lcsr_div.sv */
// ----------------------------------------------------------------------------
// lcsr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcsr_div #(
	parameter int DW = 32,
	parameter int VW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int CW = $clog2(DW);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [VW:0]   trial, diff;
	logic          ge;

	assign trial    = {rem_q, quo_q[DW-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign ge       = (trial >= {1'b0, dvs_q});
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(DW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

endmodule

/* rtl/lcsr_core.sv */
// ----------------------------------------------------------------------------
// lcsr_core
// Back end: serial clock sequencer, sample shifter, averaging and tare.
// ----------------------------------------------------------------------------
module lcsr_core #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lcsr_pkg::cfg_t        cfg,
	input  logic                  in_valid,
	input  lcsr_pkg::in_item_t    in_item,
	output logic                  in_pop,
	input  logic                  out_full,
	output logic                  out_push,
	output lcsr_pkg::out_item_t   out_item
);
	import lcsr_pkg::*;
	`include "load_cell_adc_serial_reader_assert.svh"

	localparam int SB  = SAMPLE_BITS;
	localparam int SW  = SB + 8;
	localparam int BCW = $clog2(SB + 1);
	localparam logic [SB-1:0] TOP_BIT = {1'b1, {(SB-1){1'b0}}};

	typedef enum logic [6:0] {
		PH_IDLE  = 7'b0000001,
		PH_WAIT  = 7'b0000010,
		PH_HIGH  = 7'b0000100,
		PH_LOW   = 7'b0001000,
		PH_GHIGH = 7'b0010000,
		PH_GLOW  = 7'b0100000,
		PH_PDOWN = 7'b1000000
	} phase_t;

	typedef enum logic [2:0] {
		CTL_RUN = 3'b001,
		CTL_DIV = 3'b010,
		CTL_NET = 3'b100
	} ctl_t;

	phase_t              phase_q, nx_phase;
	ctl_t                ctl_q;
	logic [BCW-1:0]      bit_q, nx_bit, bit_inc;
	logic [15:0]         tick_q, nx_tick, half_len;
	logic [SB-1:0]       shift_q, nx_shift, shift_in, fin_shift;
	logic [7:0]          rc_q, nx_rc, rc_inc, avg_n;
	logic [SW-1:0]       sum_q, nx_sum, sum_add;
	logic [VALUE_W-1:0]  last_avg_q, last_net_q, net_calc, avg_sat;
	logic [SW-1:0]       quotient;
	logic                item_go, run_phase, finish, hfin, div_start, div_done;

	assign half_len  = (cfg.half_period_ticks == '0) ? 16'd1 : cfg.half_period_ticks;
	assign hfin      = (tick_q >= half_len);
	assign avg_n     = (cfg.average_count == '0) ? 8'd1 : cfg.average_count;
	assign bit_inc   = bit_q + BCW'(1);
	assign shift_in  = {shift_q[SB-2:0], in_item.data_level};
	assign rc_inc    = rc_q + 8'd1;
	assign sum_add   = sum_q + SW'(fin_shift ^ TOP_BIT);
	assign item_go   = (ctl_q == CTL_RUN) && in_valid && !out_full;
	assign in_pop    = item_go;
	assign div_start = item_go && finish;

	always_comb begin
		nx_phase  = phase_q;
		nx_bit    = bit_q;
		nx_tick   = tick_q;
		nx_shift  = shift_q;
		nx_rc     = rc_q;
		nx_sum    = sum_q;
		finish    = 1'b0;
		run_phase = 1'b0;
		fin_shift = shift_q;
		priority if (in_item.opc == OPC_PDOWN) begin
			nx_phase = PH_PDOWN;
			nx_bit   = '0;
			nx_tick  = '0;
			nx_shift = '0;
			nx_rc    = '0;
			nx_sum   = '0;
		end else if (in_item.opc == OPC_START &&
				(phase_q == PH_IDLE || phase_q == PH_PDOWN)) begin
			nx_phase = PH_WAIT;
			nx_bit   = '0;
			nx_tick  = '0;
			nx_shift = '0;
			nx_rc    = '0;
			nx_sum   = '0;
		end else begin
			run_phase = 1'b1;
		end

		if (run_phase) begin
			unique case (phase_q)
				PH_WAIT: begin
					if (!in_item.data_level) begin
						nx_bit   = '0;
						nx_shift = '0;
						nx_phase = PH_HIGH;
						nx_tick  = 16'd1;
					end
				end
				PH_HIGH, PH_GHIGH: begin
					if (hfin) begin
						nx_phase = (phase_q == PH_HIGH) ? PH_LOW : PH_GLOW;
						nx_tick  = 16'd1;
					end else begin
						nx_tick = tick_q + 16'd1;
					end
				end
				PH_LOW: begin
					if (hfin) begin
						nx_shift  = shift_in;
						fin_shift = shift_in;
						if (bit_inc >= BCW'(SB)) begin
							nx_bit = '0;
							if (cfg.gain_pulses != '0) begin
								nx_phase = PH_GHIGH;
								nx_tick  = 16'd1;
							end else begin
								finish = 1'b1;
							end
						end else begin
							nx_bit   = bit_inc;
							nx_phase = PH_HIGH;
							nx_tick  = 16'd1;
						end
					end else begin
						nx_tick = tick_q + 16'd1;
					end
				end
				PH_GLOW: begin
					if (hfin) begin
						if (bit_inc >= BCW'(cfg.gain_pulses)) begin
							nx_bit = '0;
							finish = 1'b1;
						end else begin
							nx_bit   = bit_inc;
							nx_phase = PH_GHIGH;
							nx_tick  = 16'd1;
						end
					end else begin
						nx_tick = tick_q + 16'd1;
					end
				end
				PH_IDLE, PH_PDOWN: ;
				default: nx_phase = PH_IDLE;
			endcase
		end

		// end of one reading: accumulate, then wait for another or average
		if (finish) begin
			nx_sum  = sum_add;
			nx_rc   = rc_inc;
			nx_tick = '0;
			if (rc_inc < avg_n) begin
				nx_phase = PH_WAIT;
				finish   = 1'b0;
			end else begin
				nx_phase = PH_IDLE;
			end
		end
	end

	lcsr_div #(
		.DW(SW),
		.VW(8)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (nx_sum),
		.divisor  (avg_n),
		.done     (div_done),
		.quotient (quotient)
	);

	assign avg_sat  = (quotient > SW'({VALUE_W{1'b1}})) ? {VALUE_W{1'b1}}
	                                                    : quotient[VALUE_W-1:0];
	assign net_calc = (last_avg_q > cfg.tare_offset) ? last_avg_q - cfg.tare_offset : '0;

	always_comb begin
		out_push = 1'b0;
		out_item = '0;
		unique case (ctl_q)
			CTL_RUN: begin
				out_push = item_go && !finish;
				out_item.serial_clock  = (nx_phase == PH_HIGH || nx_phase == PH_GHIGH ||
				                          nx_phase == PH_PDOWN);
				out_item.busy_res      = !(nx_phase == PH_IDLE || nx_phase == PH_PDOWN);
				out_item.average_value = last_avg_q;
				out_item.net_value     = last_net_q;
			end
			CTL_NET: begin
				out_push = !out_full;
				out_item.done_res      = 1'b1;
				out_item.average_value = last_avg_q;
				out_item.net_value     = net_calc;
			end
			CTL_DIV: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			ctl_q      <= CTL_RUN;
			bit_q      <= '0;
			tick_q     <= '0;
			shift_q    <= '0;
			rc_q       <= '0;
			sum_q      <= '0;
			last_avg_q <= '0;
			last_net_q <= '0;
		end else begin
			unique case (ctl_q)
				CTL_RUN: begin
					if (item_go) begin
						phase_q <= nx_phase;
						bit_q   <= nx_bit;
						tick_q  <= nx_tick;
						shift_q <= nx_shift;
						rc_q    <= nx_rc;
						sum_q   <= nx_sum;
						if (finish)
							ctl_q <= CTL_DIV;
					end
				end
				CTL_DIV: begin
					if (div_done) begin
						last_avg_q <= avg_sat;
						ctl_q      <= CTL_NET;
					end
				end
				CTL_NET: begin
					if (!out_full) begin
						last_net_q <= net_calc;
						ctl_q      <= CTL_RUN;
					end
				end
				default: ctl_q <= CTL_RUN;
			endcase
		end
	end

	`LCSR_ASSERT_NOW(a_div_from_run, div_start, ctl_q == CTL_RUN, "divide started outside run")
	`LCSR_ASSERT_NEXT(a_div_follows, div_start, ctl_q == CTL_DIV, "divide start not tracked")
	`LCSR_ASSERT_NOW(a_no_push_div, ctl_q == CTL_DIV, !out_push && !in_pop,
		"transfer during divide")
	`LCSR_ASSERT_NOW(a_done_tag, out_push, out_item.done_res == (ctl_q == CTL_NET),
		"done flag on wrong result")
	`LCSR_ASSERT_NOW(a_bit_range, 1'b1, bit_q < BCW'(SB), "bit counter out of range")

endmodule
